>>> hw/rtl/blir_pkg.sv
package blir_pkg;

    // Default sizing
    localparam int CAPACITY_DEF  = 16;
    localparam int WORD_BITS_DEF = 32;

    // Fixed field widths on the stream ports
    localparam int OP_W       = 3;
    localparam int POS_W      = 4;
    localparam int WORD_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int IN_DATA_W  = 40;  // 3 + 4 + 32 = 39, padded to bytes
    localparam int OUT_DATA_W = 40;  // 32 + 2 + 5 = 39, padded to bytes

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_APPEND  = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_REPLACE = 3'd3,
        OP_READ    = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    // Broadcast command to every cell of the row
    typedef struct packed {
        logic ins_en;  // open a gap at pos, cells above take the lower neighbor
        logic rem_en;  // close the gap at pos, cells from pos take the upper neighbor
        logic wr_en;   // overwrite the cell at pos
        logic rd_en;   // drive the cell at pos onto the read bus
    } cell_ctrl_t;

endpackage

>>> hw/rtl/bounded_list_insert_remove_top.sv
// Channel  | Dir | Payload (low bit first)                          | Notes
// s_axis   | in  | tdata: op[2:0], position[6:3], word_in[38:7]    | one request per op
// m_axis   | out | tdata: read_word[31:0], status[33:32],           | one result per request
//          |     |        entry_count[38:34]                        |
//
// Each request is done in the cycle it is accepted: the whole row of cells
// shifts, writes or is read at once, and the result lands in the output
// register on the next edge, so one request per cycle is sustained while the output is drained.
// The output register is the only stall point: s_axis_tready is high while
// it is empty or being drained. rst_n (async, active low) clears the count
// and the output valid; the cell contents are left as they are.
module bounded_list_insert_remove_top
    import blir_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // op, position, word_in
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // read_word, status, entry_count
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    // Request fields
    logic [OP_W-1:0]      req_op;
    logic [POS_W-1:0]     req_pos;
    logic [WORD_BITS-1:0] req_word;

    assign req_op   = s_axis_tdata[OP_W-1:0];
    assign req_pos  = s_axis_tdata[OP_W+POS_W-1:OP_W];
    assign req_word = WORD_BITS'(s_axis_tdata[OP_W+POS_W+WORD_W-1:OP_W+POS_W]);

    logic                  accept;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      count_new;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    cell_ctrl_t            ctrl;
    logic [IDX_W-1:0]      cell_pos;
    status_t               status;
    logic                  full;
    logic [CMP_W-1:0]      pos_cmp;
    logic [CMP_W-1:0]      cnt_cmp;
    logic [WORD_BITS-1:0]  rd_word;

    logic [WORD_BITS-1:0]  cell_word [CAPACITY];
    logic [WORD_BITS-1:0]  rd_part   [CAPACITY];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Decode: validity checks and the broadcast command
    always_comb
    begin
        full      = (count_reg == CNT_FULL);
        pos_cmp   = CMP_W'(req_pos);
        cnt_cmp   = CMP_W'(count_reg);
        ctrl      = '0;
        cell_pos  = IDX_W'(req_pos);
        status    = ST_OK;
        count_new = count_reg;
        unique case (req_op)
            OP_INSERT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else if (pos_cmp > cnt_cmp)
                begin
                    status = ST_BADPOS;
                end
                else
                begin
                    ctrl.ins_en = accept;
                    count_new   = count_reg + 1'b1;
                end
            end
            OP_APPEND:
            begin
                cell_pos = IDX_W'(count_reg);
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctrl.wr_en = accept;
                    count_new  = count_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (pos_cmp >= cnt_cmp)
                begin
                    status = ST_BADPOS;
                end
                else
                begin
                    ctrl.rem_en = accept;
                    count_new   = count_reg - 1'b1;
                end
            end
            OP_REPLACE:
            begin
                if (pos_cmp >= cnt_cmp)
                begin
                    status = ST_BADPOS;
                end
                else
                begin
                    ctrl.wr_en = accept;
                end
            end
            OP_READ:
            begin
                if (pos_cmp >= cnt_cmp)
                begin
                    status = ST_BADPOS;
                end
                else
                begin
                    ctrl.rd_en = 1'b1;
                end
            end
            default:
            begin
                status = ST_BADPOS;
            end
        endcase
    end

    // Row of cells; neighbors feed each other for the shifts
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [WORD_BITS-1:0] lower;
        logic [WORD_BITS-1:0] upper;

        if (k == 0)
        begin : g_first
            assign lower = '0;
        end
        else
        begin : g_mid_lo
            assign lower = cell_word[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign upper = cell_word[k];
        end
        else
        begin : g_mid_hi
            assign upper = cell_word[k+1];
        end

        blir_cell #(
            .INDEX     (k),
            .IDX_W     (IDX_W),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .pos        (cell_pos),
            .word_in    (req_word),
            .lower_word (lower),
            .upper_word (upper),
            .word       (cell_word[k]),
            .rd_part    (rd_part[k])
        );
    end

    // Only the addressed cell drives a nonzero word
    always_comb
    begin
        rd_word = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            rd_word = rd_word | rd_part[k];
        end
    end

    always_comb
    begin
        count_next     = accept ? count_new : count_reg;
        out_valid_next = accept || (out_valid_reg && !m_axis_tready);
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_data_next = OUT_DATA_W'({COUNT_W'(count_new), status, WORD_W'(rd_word)});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> hw/rtl/blir_cell.sv
module blir_cell
    import blir_pkg::*;
#(
    parameter int INDEX     = 0,
    parameter int IDX_W     = 4,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                 clk,
    input  cell_ctrl_t           ctrl,
    input  logic [IDX_W-1:0]     pos,
    input  logic [WORD_BITS-1:0] word_in,
    input  logic [WORD_BITS-1:0] lower_word,
    input  logic [WORD_BITS-1:0] upper_word,
    output logic [WORD_BITS-1:0] word,
    output logic [WORD_BITS-1:0] rd_part
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic                 hit;

    assign hit = (pos == MY_IDX);

    always_comb
    begin
        word_next = word_reg;
        if ((ctrl.ins_en || ctrl.wr_en) && hit)
        begin
            word_next = word_in;
        end
        else if (ctrl.ins_en && (MY_IDX > pos))
        begin
            word_next = lower_word;
        end
        else if (ctrl.rem_en && (MY_IDX >= pos))
        begin
            word_next = upper_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    assign rd_part = (ctrl.rd_en && hit) ? word_reg : '0;

endmodule

>>> tb/blir_list_checker.sv
module blir_list_checker
    import blir_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // op, position, word_in
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // read_word, status, entry_count
    output int                    mismatches,
    output int                    awaiting,       // replies still owed by the block
    output int                    list_len        // predicted entry count
);

    typedef struct {
        logic [WORD_W-1:0]  read_word;
        status_t            status;
        logic [COUNT_W-1:0] entry_count;
    } list_reply_t;

    logic [WORD_W-1:0] cells [CAPACITY_DEF];
    int                n_held;
    list_reply_t       awaited_replies [$];

    task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("%0t: %s mismatch, got %h want %h", $time, field, got, want);
        mismatches++;
    endtask

    // One list operation applied to the local copy of the list.
    task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                 input logic [WORD_W-1:0] word, output list_reply_t r);
        int k;
        r.read_word = '0;
        r.status    = ST_OK;
        case (op)
            OP_INSERT:
                if (n_held >= CAPACITY_DEF)
                    r.status = ST_FULL;
                else if (pos > n_held)
                    r.status = ST_BADPOS;
                else
                begin
                    for (k = n_held; k > pos; k--)
                        cells[k] = cells[k-1];
                    cells[pos] = word;
                    n_held++;
                end
            OP_APPEND:
                if (n_held >= CAPACITY_DEF)
                    r.status = ST_FULL;
                else
                begin
                    cells[n_held] = word;
                    n_held++;
                end
            OP_REMOVE:
                if (pos >= n_held)
                    r.status = ST_BADPOS;
                else
                begin
                    for (k = pos; k + 1 < n_held; k++)
                        cells[k] = cells[k+1];
                    n_held--;
                end
            OP_REPLACE:
                if (pos >= n_held)
                    r.status = ST_BADPOS;
                else
                    cells[pos] = word;
            OP_READ:
                if (pos >= n_held)
                    r.status = ST_BADPOS;
                else
                    r.read_word = cells[pos];
            default:
                r.status = ST_BADPOS;
        endcase
        r.entry_count = n_held[COUNT_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_reply_t want;
        list_reply_t next;
        if (!rst_n)
        begin
            n_held = 0;
            awaited_replies.delete();
        end
        else
        begin
            // drain side first: a reply leaving now belongs to an older request
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_replies.size() == 0)
                    report_mismatch("unexpected reply", m_axis_tdata[31:0], '0);
                else
                begin
                    want = awaited_replies.pop_front();
                    if (m_axis_tdata[31:0] !== want.read_word)
                        report_mismatch("read_word", m_axis_tdata[31:0], want.read_word);
                    if (m_axis_tdata[33:32] !== want.status)
                        report_mismatch("status", m_axis_tdata[33:32], want.status);
                    if (m_axis_tdata[38:34] !== want.entry_count)
                        report_mismatch("entry_count", m_axis_tdata[38:34], want.entry_count);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_list_op(s_axis_tdata[2:0], s_axis_tdata[6:3], s_axis_tdata[38:7], next);
                awaited_replies.push_back(next);
            end
        end
        awaiting <= awaited_replies.size();
        list_len <= n_held;
    end

endmodule

>>> tb/tb.sv
module tb;
    import blir_pkg::*;

    // Timing budget
    localparam int QUIET_LIMIT    = 2000;  // cycles with no handshake at all
    localparam int RX_HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int TAIL_CYCLES    = 10;    // settle time after the last reply
    localparam int ITEMS_PER_PASS = 175;   // four idle patterns, ~700 requests

    // Opcodes the block does not define; it must answer them with a bad-position status
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // op, position, word_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // read_word, status, entry_count

    int mismatches;
    int awaiting;
    int list_len;

    // Idle knobs, percent of cycles
    int send_idle_pct = 0;
    int rx_stall_pct  = 0;
    bit rx_hold_start = 1'b0;
    // Random mix bias: grow toward full or shrink toward empty
    bit growing = 1'b1;

    bounded_list_insert_remove_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    blir_list_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .awaiting      (awaiting),
        .list_len      (list_len)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    // The hold is timed here so the sender keeps pushing meanwhile and the
    // single output register fills, which must drop s_axis_tready.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_start)
            begin
                rx_hold_start = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Watchdog: ends the run if the stream goes quiet for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Offer one request and return at the edge where it is taken.
    // Random idle cycles go in front; tvalid is never lowered and raised in
    // the same step, so back-to-back requests keep it high.
    task automatic send_req(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [WORD_W-1:0] word);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, word, pos, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Sender pause: nothing offered until every owed reply has come back.
    // The first edge lets the checker see the request just taken.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (awaiting != 0);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Random request. Mostly positions inside the live list so operations
    // succeed and shift real data; the rest spans the whole position field.
    // The mix swings between growing and shrinking so the list visits both
    // empty and full often.
    task automatic send_random();
        int                r;
        int                hi;
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        if (list_len >= CAPACITY_DEF && $urandom_range(0, 2) == 0)
            growing = 1'b0;
        else if (list_len == 0)
            growing = 1'b1;
        else if ($urandom_range(0, 49) == 0)
            growing = !growing;

        r = $urandom_range(0, 99);
        if (r < 30)
            op = growing ? OP_INSERT : OP_REMOVE;
        else if (r < 45)
            op = growing ? OP_APPEND : OP_REMOVE;
        else if (r < 55)
            op = growing ? OP_REMOVE : OP_INSERT;
        else if (r < 70)
            op = OP_REPLACE;
        else if (r < 95)
            op = OP_READ;
        else
            op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));

        hi = (list_len > 15) ? 15 : list_len;
        if ($urandom_range(0, 3) != 0)
            pos = POS_W'($urandom_range(0, hi));
        else
            pos = POS_W'($urandom_range(0, 15));

        send_req(op, pos, pick_word());
    endtask

    initial
    begin
        int idle_pattern [4][2];
        idle_pattern = '{'{0, 0}, '{60, 0}, '{0, 60}, '{31, 31}};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-list errors, inserts at front / middle / end,
        // then fill to capacity and hit the full cases.
        send_req(OP_READ,    4'd0,  32'h0);           // read on empty list
        send_req(OP_REMOVE,  4'd0,  32'h0);           // remove on empty list
        send_req(OP_REPLACE, 4'd0,  32'hDEADBEEF);    // replace on empty list
        send_req(OP_INSERT,  4'd1,  32'h11111111);    // insert past the count
        send_req(OP_INSERT,  4'd0,  32'hFFFFFFFF);
        send_req(OP_INSERT,  4'd1,  32'h00000000);    // position == count appends
        send_req(OP_INSERT,  4'd0,  32'h5A5A5A5A);    // insert at head
        send_req(OP_INSERT,  4'd1,  32'hA5A5A5A5);    // insert in the middle
        send_req(OP_READ,    4'd2,  32'h0);
        send_req(OP_REPLACE, 4'd3,  32'h12345678);    // replace last entry
        send_req(OP_REMOVE,  4'd1,  32'h0);           // remove from the middle
        send_req(OP_READ,    4'd3,  32'h0);           // read at position == count
        send_req(OP_UNUSED_LO, 4'd0, 32'hFFFFFFFF);
        send_req(OP_UNUSED_HI, 4'd15, 32'hFFFFFFFF);
        repeat (13) send_req(OP_APPEND, POS_W'($urandom_range(0, 15)), pick_word());
        send_req(OP_INSERT,  4'd0,  32'hCAFEF00D);    // insert into full list
        send_req(OP_APPEND,  4'd7,  32'hCAFEF00D);    // append to full list
        send_req(OP_READ,    4'd15, 32'h0);           // top entry
        send_req(OP_REMOVE,  4'd15, 32'h0);           // remove the tail
        send_req(OP_INSERT,  4'd15, 32'h80000001);    // refill through insert
        send_req(OP_REMOVE,  4'd0,  32'h0);           // remove the head
        wait_drained();

        // Random traffic under each idle pattern. The long receiver hold
        // lands in the first pass, where the sender never idles.
        for (int pass = 0; pass < 4; pass++)
        begin
            send_idle_pct = idle_pattern[pass][0];
            rx_stall_pct  = idle_pattern[pass][1];
            for (int n = 0; n < ITEMS_PER_PASS; n++)
            begin
                if (pass == 0 && n == 80)
                    rx_hold_start = 1'b1;
                // stretches with no idling inside the idling passes
                if (pass != 0 && n == ITEMS_PER_PASS / 2)
                begin
                    send_idle_pct = 0;
                    rx_stall_pct  = 0;
                end
                else if (pass != 0 && n == ITEMS_PER_PASS / 2 + 25)
                begin
                    send_idle_pct = idle_pattern[pass][0];
                    rx_stall_pct  = idle_pattern[pass][1];
                end
                send_random();
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
